FILE: hw/rtl/ocv_pkg.sv
// Shared codes, constants, state type and claim share table of the claim grid block.
package ocv_pkg;

   // Width of a region label as it arrives on the request channel.
   localparam int LBL_W = 9;

   // Width of a per-label vote total, unsigned Q12.24 after weighting.
   localparam int VT_W = 36;

   // Claim values in Q1.16.
   localparam logic [16:0] Q_ONE  = 17'd65536;
   localparam logic [16:0] Q_HALF = 17'd32768;

   // Fill map codes.
   localparam logic [1:0] MAP_EMPTY    = 2'd0;
   localparam logic [1:0] MAP_INTERIOR = 2'd1;
   localparam logic [1:0] MAP_OUTLINE  = 2'd2;

   // Request codes.
   localparam logic [2:0] REQ_START  = 3'd0;
   localparam logic [2:0] REQ_POINT  = 3'd1;
   localparam logic [2:0] REQ_CLOSE  = 3'd2;
   localparam logic [2:0] REQ_ASSIGN = 3'd3;
   localparam logic [2:0] REQ_ZERO   = 3'd4;
   localparam logic [2:0] REQ_READ   = 3'd5;
   localparam logic [2:0] REQ_CLEAR  = 3'd6;

   // Status codes.
   localparam logic [2:0] STS_OK    = 3'd0;
   localparam logic [2:0] STS_LABEL = 3'd1;
   localparam logic [2:0] STS_SEED  = 3'd2;
   localparam logic [2:0] STS_POINT = 3'd3;
   localparam logic [2:0] STS_PIXEL = 3'd4;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CENTER = 2'd2;
   localparam logic [1:0] CSR_SIDE   = 2'd3;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RCLR,
      ST_PT_WR,
      ST_SEED,
      ST_SEED_CHK,
      ST_POP,
      ST_POP_W,
      ST_NB_RD,
      ST_NB_CHK,
      ST_CL,
      ST_ZO,
      ST_RD_W,
      ST_VN_RD,
      ST_VN_W,
      ST_VA_RD,
      ST_VA_ADD,
      ST_VW,
      ST_DONE
   } state_type;

   // Share of one claim when a pixel holds n claims, floor(65536 / n) for n from 1 to 8; other n give 65536.
   function automatic logic [16:0] q_share(input logic [3:0] n);
      logic [16:0] r;
      unique case (n)
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21845;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13107;
         4'd6:    r = 17'd10922;
         4'd7:    r = 17'd9362;
         4'd8:    r = 17'd8192;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/ocv_claim_value.sv
// Values the claim set of one pixel: the share of each claim and the no-label share.
module ocv_claim_value #(
   parameter int MAX_CLAIMS = 4
) (
   input  logic [$clog2(MAX_CLAIMS+1)-1:0] count,
   input  logic                            interior,
   output logic [$clog2(MAX_CLAIMS+1)-1:0] n_eff,
   output logic [16:0]                     val,
   output logic [16:0]                     nol
);

   localparam int CNTW = $clog2(MAX_CLAIMS + 1);

   // Clip the count to the list size, then pick the value by case.
   always_comb begin
      n_eff = (count > CNTW'(MAX_CLAIMS)) ? CNTW'(MAX_CLAIMS) : count;
      val   = '0;
      nol   = '0;
      if (n_eff == '0) begin
         nol = ocv_pkg::Q_HALF;
      end else if (n_eff == CNTW'(1)) begin
         if (interior) begin
            val = ocv_pkg::Q_ONE;
         end else begin
            val = ocv_pkg::Q_HALF;
            nol = ocv_pkg::Q_HALF;
         end
      end else begin
         val = ocv_pkg::q_share(4'(n_eff));
      end
   end

endmodule

FILE: hw/rtl/outline_claim_label_vote.sv
// Top level of the outline claim grid with weighted 3x3 label vote.
//
// Requests arrive on the req_ channel (valid/stall); each request gives exactly
// one beat on the rsp_ channel with a status code and, for a read, the label.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// do so only while idle, as the block itself does not enforce it. The block
// works on one request at a time; its sequencer walks the grid, fill map,
// fill stack and vote memories, with one read and one write port on each.
// Work per request, from acceptance to the result beat:
//   point: the outline mark is written; read: the label is read from the grid;
//   start: the fill map is swept one entry a cycle;
//   close: fill by pops and in-area neighbour checks, then the claim pass;
//   assign: per pixel in the area, a read of each neighbour, a vote per
//          valued claim and a write back;
//   zero outlines: a pass over the area; clear: a sweep of the whole grid.
// After reset the block sweeps the whole grid and holds req_stall high until
// that is done. A stalled result stays in the output register; the block
// finishes its work and waits there.
module outline_claim_label_vote #(
   parameter int GRID_W     = 64,
   parameter int GRID_H     = 64,
   parameter int MAX_CLAIMS = 4,
   parameter int LABEL_MAX  = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [8:0]  req_region_label,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_pixel_label,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int NPIX = GRID_W * GRID_H;
   localparam int AW   = $clog2(NPIX);
   localparam int XW   = $clog2(GRID_W);
   localparam int YW   = $clog2(GRID_H);
   localparam int SPW  = $clog2(NPIX + 1);
   localparam int CNTW = $clog2(MAX_CLAIMS + 1);
   localparam int SIW  = (MAX_CLAIMS > 1) ? $clog2(MAX_CLAIMS) : 1;
   localparam int LW   = ocv_pkg::LBL_W;
   localparam int VTW  = ocv_pkg::VT_W;
   localparam int VN   = ((LABEL_MAX < 511) ? LABEL_MAX : 511) + 1;
   localparam int VAW  = $clog2(VN);
   localparam int CWA  = ($clog2(GRID_W + 1) > 8) ? $clog2(GRID_W + 1) : 8;
   localparam int CW   = ($clog2(GRID_H + 1) > CWA) ? $clog2(GRID_H + 1) : CWA;

   typedef struct packed {
      logic [MAX_CLAIMS-1:0][LW-1:0] labels;
      logic [CNTW-1:0]               count;
      logic                          interior;
      logic                          omark;
      logic [LW-1:0]                 label;
   } grid_word_type;

   // Memories with registered read data.
   grid_word_type grid_mem [NPIX];
   logic [1:0]    rmap_mem [NPIX];
   logic [XW+YW-1:0] stk_mem [NPIX];
   logic [VTW-1:0] vote_mem [VN];

   logic grid_we, grid_re, rmap_we, rmap_re, stk_we, stk_re, vote_we, vote_re;
   logic [AW-1:0] grid_waddr, grid_raddr, rmap_waddr, rmap_raddr, stk_waddr, stk_raddr;
   logic [VAW-1:0] vote_waddr, vote_raddr;
   grid_word_type grid_wdata, grid_rdata;
   logic [1:0] rmap_wdata, rmap_rdata;
   logic [XW+YW-1:0] stk_wdata, stk_rdata;
   logic [VTW-1:0] vote_wdata, vote_rdata;

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
      if (grid_re) grid_rdata <= grid_mem[grid_raddr];
   end

   always_ff @(posedge clock) begin
      if (rmap_we) rmap_mem[rmap_waddr] <= rmap_wdata;
      if (rmap_re) rmap_rdata <= rmap_mem[rmap_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      if (stk_re) stk_rdata <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (vote_we) vote_mem[vote_waddr] <= vote_wdata;
      if (vote_re) vote_rdata <= vote_mem[vote_raddr];
   end

   // Control and datapath registers.
   ocv_pkg::state_type state_ff, state_in;
   logic            open_ff, open_in;
   logic [LW-1:0]   ctx_lbl_ff, ctx_lbl_in;
   logic [7:0]      seed_x_ff, seed_x_in, seed_y_ff, seed_y_in;
   logic [AW-1:0]   pt_addr_ff, pt_addr_in;
   logic [2:0]      status_ff, status_in;
   logic [7:0]      pix_ff, pix_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [7:0]      rsp_pixel_ff, rsp_pixel_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [SPW-1:0]  sp_ff, sp_in;
   logic [XW-1:0]   cur_x_ff, cur_x_in, nb_x_ff, nb_x_in, scan_x_ff, scan_x_in;
   logic [YW-1:0]   cur_y_ff, cur_y_in, nb_y_ff, nb_y_in, scan_y_ff, scan_y_in;
   logic [1:0]      k_ff, k_in, dx_ff, dx_in, dy_ff, dy_in;
   logic            issue_ff, issue_in, pipe_v_ff, pipe_v_in;
   logic [AW-1:0]   pipe_addr_ff, pipe_addr_in;
   grid_word_type   nb_word_ff, nb_word_in, ctr_word_ff, ctr_word_in;
   logic            nb_ctr_ff, nb_ctr_in;
   logic [CNTW-1:0] slot_ff, slot_in;
   logic [32:0]     prod_ff, prod_in;
   logic [VAW-1:0]  vlab_ff, vlab_in;
   logic [LW-1:0]   best_lbl_ff, best_lbl_in;
   logic [VTW-1:0]  best_tot_ff, best_tot_in;
   logic [VN-1:0]   vvalid_ff, vvalid_in;
   logic [6:0]      width_ff, width_in, height_ff, height_in;
   logic [15:0]     cw_ff, cw_in, sw_ff, sw_in;

   // Effective area in use.
   logic [CW-1:0] eff_w, eff_h;
   assign eff_w = (CW'(width_ff) < CW'(GRID_W)) ? CW'(width_ff) : CW'(GRID_W);
   assign eff_h = (CW'(height_ff) < CW'(GRID_H)) ? CW'(height_ff) : CW'(GRID_H);

   function automatic logic pos_ok(input logic [7:0] p, input logic [CW-1:0] lim);
      return !p[7] && (CW'(p[6:0]) < lim);
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
      return AW'(AW'(y) * AW'(GRID_W)) + AW'(x);
   endfunction

   // Valuation of the neighbour word under vote.
   logic [CNTW-1:0] cv_n;
   logic [16:0]     cv_val, cv_nol;

   ocv_claim_value #(.MAX_CLAIMS(MAX_CLAIMS)) u_value (
      .count    (nb_word_ff.count),
      .interior (nb_word_ff.interior),
      .n_eff    (cv_n),
      .val      (cv_val),
      .nol      (cv_nol)
   );

   // Scan position helpers shared by the area passes.
   logic scan_xe, scan_ye, scan_last;
   logic [AW-1:0] scan_addr;
   assign scan_xe   = (CW'(scan_x_ff) + CW'(1)) == eff_w;
   assign scan_ye   = (CW'(scan_y_ff) + CW'(1)) == eff_h;
   assign scan_last = scan_xe && scan_ye;
   assign scan_addr = addr_of(scan_x_ff, scan_y_ff);

   // Four-connected neighbour of the popped fill pixel.
   logic          fok;
   logic [XW-1:0] fnx;
   logic [YW-1:0] fny;
   always_comb begin
      fnx = cur_x_ff;
      fny = cur_y_ff;
      unique case (k_ff)
         2'd0: begin
            fok = (CW'(cur_x_ff) + CW'(1)) < eff_w;
            fnx = cur_x_ff + XW'(1);
         end
         2'd1: begin
            fok = cur_x_ff != '0;
            fnx = cur_x_ff - XW'(1);
         end
         2'd2: begin
            fok = (CW'(cur_y_ff) + CW'(1)) < eff_h;
            fny = cur_y_ff + YW'(1);
         end
         2'd3: begin
            fok = cur_y_ff != '0;
            fny = cur_y_ff - YW'(1);
         end
      endcase
   end

   // 3x3 neighbour of the voting pixel; codes 0, 1, 2 mean -1, 0, +1.
   logic          vok_x, vok_y, nb_last;
   logic [XW-1:0] vnx;
   logic [YW-1:0] vny;
   logic [1:0]    ndx, ndy;
   always_comb begin
      vnx = scan_x_ff;
      vny = scan_y_ff;
      unique case (dx_ff)
         2'd0: begin
            vok_x = scan_x_ff != '0;
            vnx   = scan_x_ff - XW'(1);
         end
         2'd1: vok_x = 1'b1;
         2'd2: begin
            vok_x = (CW'(scan_x_ff) + CW'(1)) < eff_w;
            vnx   = scan_x_ff + XW'(1);
         end
         default: vok_x = 1'b0;
      endcase
      unique case (dy_ff)
         2'd0: begin
            vok_y = scan_y_ff != '0;
            vny   = scan_y_ff - YW'(1);
         end
         2'd1: vok_y = 1'b1;
         2'd2: begin
            vok_y = (CW'(scan_y_ff) + CW'(1)) < eff_h;
            vny   = scan_y_ff + YW'(1);
         end
         default: vok_y = 1'b0;
      endcase
      nb_last = (dx_ff == 2'd2) && (dy_ff == 2'd2);
      ndx = (dx_ff == 2'd2) ? 2'd0 : dx_ff + 2'd1;
      ndy = (dx_ff == 2'd2) ? dy_ff + 2'd1 : dy_ff;
   end

   // Claim slot being valued: the listed claims, then the no-label share.
   logic          slot_v;
   logic [LW-1:0] slot_lbl;
   logic [16:0]   slot_val;
   always_comb begin
      slot_v   = 1'b0;
      slot_lbl = '0;
      slot_val = cv_nol;
      if (slot_ff < cv_n) begin
         slot_v   = 1'b1;
         slot_lbl = nb_word_ff.labels[SIW'(slot_ff)];
         slot_val = cv_val;
      end else if (slot_ff == CNTW'(MAX_CLAIMS) && cv_nol != '0) begin
         slot_v = 1'b1;
      end
   end

   // Request decode at the input.
   logic          req_acc, req_in_area;
   logic [AW-1:0] req_addr;
   assign req_acc     = req_valid && !req_stall;
   assign req_in_area = pos_ok(req_pos_x, eff_w) && pos_ok(req_pos_y, eff_h);
   assign req_addr    = addr_of(XW'(req_pos_x[6:0]), YW'(req_pos_y[6:0]));

   logic          seed_ok;
   logic [XW-1:0] seed_xc;
   logic [YW-1:0] seed_yc;
   assign seed_ok = pos_ok(seed_x_ff, eff_w) && pos_ok(seed_y_ff, eff_h);
   assign seed_xc = XW'(seed_x_ff[6:0]);
   assign seed_yc = YW'(seed_y_ff[6:0]);

   logic [VTW-1:0] vote_old, vote_tot;
   assign vote_old = vvalid_ff[vlab_ff] ? vote_rdata : '0;
   assign vote_tot = vote_old + VTW'(prod_ff);

   assign req_stall       = state_ff != ocv_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pixel_label = rsp_pixel_ff;

   // State register and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ocv_pkg::ST_CLEAR;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         sp_ff        <= '0;
         issue_ff     <= 1'b0;
         pipe_v_ff    <= 1'b0;
         vvalid_ff    <= '0;
         width_ff     <= 7'd64;
         height_ff    <= 7'd64;
         cw_ff        <= 16'd256;
         sw_ff        <= 16'd128;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_rsp_ff   <= clr_rsp_in;
         clr_addr_ff  <= clr_addr_in;
         sp_ff        <= sp_in;
         issue_ff     <= issue_in;
         pipe_v_ff    <= pipe_v_in;
         vvalid_ff    <= vvalid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         cw_ff        <= cw_in;
         sw_ff        <= sw_in;
      end
      ctx_lbl_ff    <= ctx_lbl_in;
      seed_x_ff     <= seed_x_in;
      seed_y_ff     <= seed_y_in;
      pt_addr_ff    <= pt_addr_in;
      status_ff     <= status_in;
      pix_ff        <= pix_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      nb_x_ff       <= nb_x_in;
      nb_y_ff       <= nb_y_in;
      scan_x_ff     <= scan_x_in;
      scan_y_ff     <= scan_y_in;
      k_ff          <= k_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      pipe_addr_ff  <= pipe_addr_in;
      nb_word_ff    <= nb_word_in;
      ctr_word_ff   <= ctr_word_in;
      nb_ctr_ff     <= nb_ctr_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      vlab_ff       <= vlab_in;
      best_lbl_ff   <= best_lbl_in;
      best_tot_ff   <= best_tot_in;
   end

   // Next state, register updates and memory accesses.
   always_comb begin
      grid_word_type w;

      state_in      = state_ff;
      open_in       = open_ff;
      ctx_lbl_in    = ctx_lbl_ff;
      seed_x_in     = seed_x_ff;
      seed_y_in     = seed_y_ff;
      pt_addr_in    = pt_addr_ff;
      status_in     = status_ff;
      pix_in        = pix_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      clr_rsp_in    = clr_rsp_ff;
      clr_addr_in   = clr_addr_ff;
      sp_in         = sp_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      nb_x_in       = nb_x_ff;
      nb_y_in       = nb_y_ff;
      scan_x_in     = scan_x_ff;
      scan_y_in     = scan_y_ff;
      k_in          = k_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      issue_in      = issue_ff;
      pipe_v_in     = 1'b0;
      pipe_addr_in  = pipe_addr_ff;
      nb_word_in    = nb_word_ff;
      ctr_word_in   = ctr_word_ff;
      nb_ctr_in     = nb_ctr_ff;
      slot_in       = slot_ff;
      prod_in       = prod_ff;
      vlab_in       = vlab_ff;
      best_lbl_in   = best_lbl_ff;
      best_tot_in   = best_tot_ff;
      vvalid_in     = vvalid_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      cw_in         = cw_ff;
      sw_in         = sw_ff;

      grid_we = 1'b0; grid_waddr = '0; grid_wdata = '0; grid_re = 1'b0; grid_raddr = '0;
      rmap_we = 1'b0; rmap_waddr = '0; rmap_wdata = '0; rmap_re = 1'b0; rmap_raddr = '0;
      stk_we  = 1'b0; stk_waddr  = '0; stk_wdata  = '0; stk_re  = 1'b0; stk_raddr  = '0;
      vote_we = 1'b0; vote_waddr = '0; vote_wdata = '0; vote_re = 1'b0; vote_raddr = '0;
      w = grid_rdata;

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index)
            ocv_pkg::CSR_WIDTH:  width_in  = csr_wdata[6:0];
            ocv_pkg::CSR_HEIGHT: height_in = csr_wdata[6:0];
            ocv_pkg::CSR_CENTER: cw_in     = csr_wdata;
            ocv_pkg::CSR_SIDE:   sw_in     = csr_wdata;
         endcase
      end

      unique case (state_ff)
         // Whole-grid clear, after reset and for the clear request.
         ocv_pkg::ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_addr_ff;
            rmap_we    = 1'b1;
            rmap_waddr = clr_addr_ff;
            rmap_wdata = ocv_pkg::MAP_EMPTY;
            open_in    = 1'b0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(NPIX - 1)) begin
               state_in = clr_rsp_ff ? ocv_pkg::ST_DONE : ocv_pkg::ST_IDLE;
            end
         end

         // Take a request and start its work.
         ocv_pkg::ST_IDLE: begin
            if (req_acc) begin
               status_in = ocv_pkg::STS_OK;
               pix_in    = '0;
               state_in  = ocv_pkg::ST_DONE;
               scan_x_in = '0;
               scan_y_in = '0;
               issue_in  = (eff_w != '0) && (eff_h != '0);
               unique case (req_type)
                  ocv_pkg::REQ_START: begin
                     open_in = 1'b0;
                     if (req_region_label > LW'(LABEL_MAX)) begin
                        status_in = ocv_pkg::STS_LABEL;
                     end else if (!req_in_area) begin
                        status_in = ocv_pkg::STS_SEED;
                     end else begin
                        open_in     = 1'b1;
                        ctx_lbl_in  = req_region_label;
                        seed_x_in   = req_pos_x;
                        seed_y_in   = req_pos_y;
                        clr_addr_in = '0;
                        state_in    = ocv_pkg::ST_RCLR;
                     end
                  end
                  ocv_pkg::REQ_POINT: begin
                     if (!req_in_area) begin
                        status_in = ocv_pkg::STS_POINT;
                        open_in   = 1'b0;
                     end else if (open_ff) begin
                        rmap_we    = 1'b1;
                        rmap_waddr = req_addr;
                        rmap_wdata = ocv_pkg::MAP_OUTLINE;
                        grid_re    = 1'b1;
                        grid_raddr = req_addr;
                        pt_addr_in = req_addr;
                        state_in   = ocv_pkg::ST_PT_WR;
                     end
                  end
                  ocv_pkg::REQ_CLOSE: begin
                     if (open_ff) state_in = ocv_pkg::ST_SEED;
                  end
                  ocv_pkg::REQ_ASSIGN: begin
                     dx_in       = '0;
                     dy_in       = '0;
                     vvalid_in   = '0;
                     best_lbl_in = '0;
                     best_tot_in = '0;
                     if ((eff_w != '0) && (eff_h != '0)) state_in = ocv_pkg::ST_VN_RD;
                  end
                  ocv_pkg::REQ_ZERO: begin
                     state_in = ocv_pkg::ST_ZO;
                  end
                  ocv_pkg::REQ_READ: begin
                     if (req_in_area) begin
                        grid_re    = 1'b1;
                        grid_raddr = req_addr;
                        state_in   = ocv_pkg::ST_RD_W;
                     end else begin
                        status_in = ocv_pkg::STS_PIXEL;
                     end
                  end
                  ocv_pkg::REQ_CLEAR: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ocv_pkg::ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end

         // Fill map sweep for a new region.
         ocv_pkg::ST_RCLR: begin
            rmap_we     = 1'b1;
            rmap_waddr  = clr_addr_ff;
            rmap_wdata  = ocv_pkg::MAP_EMPTY;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(NPIX - 1)) state_in = ocv_pkg::ST_DONE;
         end

         // Set the permanent outline mark.
         ocv_pkg::ST_PT_WR: begin
            w.omark    = 1'b1;
            grid_we    = 1'b1;
            grid_waddr = pt_addr_ff;
            grid_wdata = w;
            state_in   = ocv_pkg::ST_DONE;
         end

         // Seed check before the fill.
         ocv_pkg::ST_SEED: begin
            if (seed_ok) begin
               rmap_re    = 1'b1;
               rmap_raddr = addr_of(seed_xc, seed_yc);
               state_in   = ocv_pkg::ST_SEED_CHK;
            end else begin
               state_in = ocv_pkg::ST_CL;
            end
         end

         ocv_pkg::ST_SEED_CHK: begin
            if (rmap_rdata == ocv_pkg::MAP_EMPTY) begin
               rmap_we    = 1'b1;
               rmap_waddr = addr_of(seed_xc, seed_yc);
               rmap_wdata = ocv_pkg::MAP_INTERIOR;
               stk_we     = 1'b1;
               stk_waddr  = '0;
               stk_wdata  = {seed_yc, seed_xc};
               sp_in      = SPW'(1);
               state_in   = ocv_pkg::ST_POP;
            end else begin
               state_in = ocv_pkg::ST_CL;
            end
         end

         // Pop the next fill pixel.
         ocv_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               state_in = ocv_pkg::ST_CL;
            end else begin
               sp_in     = sp_ff - SPW'(1);
               stk_re    = 1'b1;
               stk_raddr = AW'(sp_ff - SPW'(1));
               state_in  = ocv_pkg::ST_POP_W;
            end
         end

         ocv_pkg::ST_POP_W: begin
            cur_x_in = stk_rdata[XW-1:0];
            cur_y_in = stk_rdata[XW+YW-1:XW];
            k_in     = '0;
            state_in = ocv_pkg::ST_NB_RD;
         end

         // Look at one neighbour of the popped pixel.
         ocv_pkg::ST_NB_RD: begin
            if (fok) begin
               rmap_re    = 1'b1;
               rmap_raddr = addr_of(fnx, fny);
               nb_x_in    = fnx;
               nb_y_in    = fny;
               state_in   = ocv_pkg::ST_NB_CHK;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = (k_ff == 2'd3) ? ocv_pkg::ST_POP : ocv_pkg::ST_NB_RD;
            end
         end

         ocv_pkg::ST_NB_CHK: begin
            if (rmap_rdata == ocv_pkg::MAP_EMPTY && sp_ff < SPW'(NPIX)) begin
               rmap_we    = 1'b1;
               rmap_waddr = addr_of(nb_x_ff, nb_y_ff);
               rmap_wdata = ocv_pkg::MAP_INTERIOR;
               stk_we     = 1'b1;
               stk_waddr  = AW'(sp_ff);
               stk_wdata  = {nb_y_ff, nb_x_ff};
               sp_in      = sp_ff + SPW'(1);
            end
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? ocv_pkg::ST_POP : ocv_pkg::ST_NB_RD;
         end

         // Claim pass over the area after the fill.
         ocv_pkg::ST_CL: begin
            if (issue_ff) begin
               grid_re      = 1'b1;
               grid_raddr   = scan_addr;
               rmap_re      = 1'b1;
               rmap_raddr   = scan_addr;
               pipe_addr_in = scan_addr;
               pipe_v_in    = 1'b1;
               scan_x_in    = scan_xe ? '0 : scan_x_ff + XW'(1);
               scan_y_in    = scan_xe ? scan_y_ff + YW'(1) : scan_y_ff;
               if (scan_last) issue_in = 1'b0;
            end
            if (pipe_v_ff) begin
               if (rmap_rdata == ocv_pkg::MAP_INTERIOR) begin
                  w.count     = CNTW'(1);
                  w.interior  = 1'b1;
                  w.labels[0] = ctx_lbl_ff;
               end else if (rmap_rdata == ocv_pkg::MAP_OUTLINE &&
                            grid_rdata.count < CNTW'(MAX_CLAIMS)) begin
                  w.labels[SIW'(grid_rdata.count)] = ctx_lbl_ff;
                  w.count    = grid_rdata.count + CNTW'(1);
                  w.interior = 1'b0;
               end
               grid_we    = 1'b1;
               grid_waddr = pipe_addr_ff;
               grid_wdata = w;
            end
            if (!issue_ff && !pipe_v_ff) begin
               open_in  = 1'b0;
               state_in = ocv_pkg::ST_DONE;
            end
         end

         // Zero labels at outline pixels.
         ocv_pkg::ST_ZO: begin
            if (issue_ff) begin
               grid_re      = 1'b1;
               grid_raddr   = scan_addr;
               pipe_addr_in = scan_addr;
               pipe_v_in    = 1'b1;
               scan_x_in    = scan_xe ? '0 : scan_x_ff + XW'(1);
               scan_y_in    = scan_xe ? scan_y_ff + YW'(1) : scan_y_ff;
               if (scan_last) issue_in = 1'b0;
            end
            if (pipe_v_ff && grid_rdata.omark) begin
               w.label    = '0;
               grid_we    = 1'b1;
               grid_waddr = pipe_addr_ff;
               grid_wdata = w;
            end
            if (!issue_ff && !pipe_v_ff) state_in = ocv_pkg::ST_DONE;
         end

         ocv_pkg::ST_RD_W: begin
            pix_in   = grid_rdata.label[7:0];
            state_in = ocv_pkg::ST_DONE;
         end

         // Vote: fetch one neighbour of the pixel under vote.
         ocv_pkg::ST_VN_RD: begin
            if (vok_x && vok_y) begin
               grid_re    = 1'b1;
               grid_raddr = addr_of(vnx, vny);
               nb_ctr_in  = (dx_ff == 2'd1) && (dy_ff == 2'd1);
               state_in   = ocv_pkg::ST_VN_W;
            end else begin
               dx_in    = ndx;
               dy_in    = ndy;
               state_in = nb_last ? ocv_pkg::ST_VW : ocv_pkg::ST_VN_RD;
            end
         end

         ocv_pkg::ST_VN_W: begin
            nb_word_in = grid_rdata;
            if (nb_ctr_ff) ctr_word_in = grid_rdata;
            slot_in  = '0;
            state_in = ocv_pkg::ST_VA_RD;
         end

         // Weight one claim and fetch its running total.
         ocv_pkg::ST_VA_RD: begin
            if (slot_v) begin
               vote_re    = 1'b1;
               vote_raddr = VAW'(slot_lbl);
               vlab_in    = VAW'(slot_lbl);
               prod_in    = 33'(nb_ctr_ff ? cw_ff : sw_ff) * 33'(slot_val);
               state_in   = ocv_pkg::ST_VA_ADD;
            end else if (slot_ff == CNTW'(MAX_CLAIMS)) begin
               dx_in    = ndx;
               dy_in    = ndy;
               state_in = nb_last ? ocv_pkg::ST_VW : ocv_pkg::ST_VN_RD;
            end else begin
               slot_in = slot_ff + CNTW'(1);
            end
         end

         // Add to the total and keep the running best, lowest label on a tie.
         ocv_pkg::ST_VA_ADD: begin
            vote_we    = 1'b1;
            vote_waddr = vlab_ff;
            vote_wdata = vote_tot;
            vvalid_in[vlab_ff] = 1'b1;
            if (vote_tot > best_tot_ff ||
                (vote_tot == best_tot_ff && LW'(vlab_ff) < best_lbl_ff)) begin
               best_tot_in = vote_tot;
               best_lbl_in = LW'(vlab_ff);
            end
            if (slot_ff == CNTW'(MAX_CLAIMS)) begin
               dx_in    = ndx;
               dy_in    = ndy;
               state_in = nb_last ? ocv_pkg::ST_VW : ocv_pkg::ST_VN_RD;
            end else begin
               slot_in  = slot_ff + CNTW'(1);
               state_in = ocv_pkg::ST_VA_RD;
            end
         end

         // Write the winning label and move to the next pixel.
         ocv_pkg::ST_VW: begin
            w          = ctr_word_ff;
            w.label    = best_lbl_ff;
            grid_we    = 1'b1;
            grid_waddr = scan_addr;
            grid_wdata = w;
            vvalid_in   = '0;
            best_lbl_in = '0;
            best_tot_in = '0;
            dx_in       = '0;
            dy_in       = '0;
            scan_x_in   = scan_xe ? '0 : scan_x_ff + XW'(1);
            scan_y_in   = scan_xe ? scan_y_ff + YW'(1) : scan_y_ff;
            state_in    = scan_last ? ocv_pkg::ST_DONE : ocv_pkg::ST_VN_RD;
         end

         // Hand the result to the output register once it is free.
         ocv_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pixel_in  = pix_ff;
               clr_rsp_in    = 1'b0;
               state_in      = ocv_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // A taken request always starts work.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ocv_pkg::ST_IDLE))
      else $error("request taken but sequencer stayed idle");

   // The fill stack never grows past the grid.
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(NPIX))
      else $error("fill stack overflow");

   // A result beat appears only from the hand-off state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ocv_pkg::ST_DONE))
      else $error("result raised outside hand-off");

endmodule
